/* rtl/snrdb_pkg.sv */
// Package for the SNR dB meter: widths, status codes, shared types and the
// log2 fraction function used to build the lookup table at elaboration.
// No dependencies.
package snrdb_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int LOG_TABLE_BITS_DEF = 6;

    localparam int ENERGY_WIDTH = 64;
    localparam int POS_WIDTH    = $clog2(ENERGY_WIDTH);
    localparam int FRAC_WIDTH   = 16;
    localparam int LOG_WIDTH    = POS_WIDTH + FRAC_WIDTH;
    localparam int COEF_WIDTH   = 18;
    localparam int PROD_WIDTH   = LOG_WIDTH + COEF_WIDTH;
    localparam int ROUND_SHIFT  = 24;
    localparam int SNR_WIDTH    = 17;
    localparam int STATUS_WIDTH = 2;
    localparam int OUT_DATA_WIDTH = ((SNR_WIDTH + 7) / 8) * 8;
    localparam int OUT_USER_WIDTH = STATUS_WIDTH + 1;

    // 10*log10(2) in Q16
    localparam logic [COEF_WIDTH-1:0] DB_PER_LOG2_Q16 = COEF_WIDTH'(197283);
    localparam logic signed [SNR_WIDTH-1:0] SNR_MAX = SNR_WIDTH'(65535);

    localparam logic [STATUS_WIDTH-1:0] ST_NORMAL    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_ERR_ZERO  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_SIG_ZERO  = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_BOTH_ZERO = 2'd3;

    typedef struct packed {
        logic [ENERGY_WIDTH-1:0] sig_energy;
        logic [ENERGY_WIDTH-1:0] err_energy;
        logic                    clip;
    } t_snap;

    typedef struct packed {
        logic signed [SNR_WIDTH-1:0] snr;
        logic [STATUS_WIDTH-1:0]     status;
        logic                        sat;
    } t_result;

    // Fraction of log2(1 + idx/2^tbits) by repeated squaring of a Q30 mantissa.
    // Only ever called with constant arguments.
    function automatic logic [FRAC_WIDTH-1:0] log_frac(input int idx, input int tbits);
        logic [63:0]           m;
        logic [FRAC_WIDTH-1:0] f;
        m = (64'(1) << 30) + (64'(idx) << (30 - tbits));
        f = '0;
        for (int b = FRAC_WIDTH - 1; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m[31]) begin
                f[b] = 1'b1;
                m    = m >> 1;
            end
        end
        return f;
    endfunction

    // Position of the leading one; zero for a zero input.
    function automatic logic [POS_WIDTH-1:0] lead_one(input logic [ENERGY_WIDTH-1:0] v);
        logic [POS_WIDTH-1:0] p;
        p = '0;
        for (int i = 0; i < ENERGY_WIDTH; i++) begin
            if (v[i]) begin
                p = POS_WIDTH'(i);
            end
        end
        return p;
    endfunction

endpackage

/* rtl/snrdb_accum.sv */
// Input register, squaring stage and saturating energy accumulators.
// Emits a snapshot of both sums and the clip flag on each last sample.
// Depends on snrdb_pkg.
module snrdb_accum #(
    parameter int SAMPLE_WIDTH = snrdb_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_orig,
    input  logic signed [SAMPLE_WIDTH-1:0] i_mod,
    input  logic                           i_last,
    output logic                           o_snap_valid,
    output snrdb_pkg::t_snap               o_snap
);

    localparam int EW = snrdb_pkg::ENERGY_WIDTH;

    logic                           r0_valid;
    logic signed [SAMPLE_WIDTH-1:0] r0_orig;
    logic signed [SAMPLE_WIDTH-1:0] r0_mod;
    logic                           r0_last;

    logic                           r1_valid;
    logic                           r1_last;
    logic [2*SAMPLE_WIDTH-1:0]      r1_sq_sig;
    logic [2*SAMPLE_WIDTH+1:0]      r1_sq_err;

    logic [EW-1:0]                  r_sig_acc;
    logic [EW-1:0]                  r_err_acc;
    logic                           r_clip;

    logic                           r2_valid;
    snrdb_pkg::t_snap               r2_snap;

    logic signed [SAMPLE_WIDTH:0]     w_diff;
    logic signed [2*SAMPLE_WIDTH-1:0] w_prod_sig;
    logic signed [2*SAMPLE_WIDTH+1:0] w_prod_err;
    logic [EW:0]                      w_sum_sig;
    logic [EW:0]                      w_sum_err;
    logic [EW-1:0]                    n_sig_acc;
    logic [EW-1:0]                    n_err_acc;
    logic                             n_clip;

    assign w_diff     = r0_orig - r0_mod;
    assign w_prod_sig = r0_orig * r0_orig;
    assign w_prod_err = w_diff * w_diff;

    assign w_sum_sig = {1'b0, r_sig_acc} + (EW + 1)'(r1_sq_sig);
    assign w_sum_err = {1'b0, r_err_acc} + (EW + 1)'(r1_sq_err);

    always_comb begin
        n_sig_acc = w_sum_sig[EW] ? {EW{1'b1}} : w_sum_sig[EW-1:0];
        n_err_acc = w_sum_err[EW] ? {EW{1'b1}} : w_sum_err[EW-1:0];
        n_clip    = r_clip | w_sum_sig[EW] | w_sum_err[EW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid  <= 1'b0;
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r_sig_acc <= '0;
            r_err_acc <= '0;
            r_clip    <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid & r1_last;
            if (r1_valid) begin
                if (r1_last) begin
                    r_sig_acc <= '0;
                    r_err_acc <= '0;
                    r_clip    <= 1'b0;
                end else begin
                    r_sig_acc <= n_sig_acc;
                    r_err_acc <= n_err_acc;
                    r_clip    <= n_clip;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_orig   <= i_orig;
            r0_mod    <= i_mod;
            r0_last   <= i_last;
            r1_last   <= r0_last;
            r1_sq_sig <= $unsigned(w_prod_sig);
            r1_sq_err <= $unsigned(w_prod_err);
            r2_snap.sig_energy <= n_sig_acc;
            r2_snap.err_energy <= n_err_acc;
            r2_snap.clip       <= n_clip;
        end
    end

    assign o_snap_valid = r2_valid;
    assign o_snap       = r2_snap;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r1_valid && r1_last) |=>
            (r_sig_acc == '0 && r_err_acc == '0 && !r_clip))
        else $error("energy sums not cleared after last sample");

    a_snap_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !(r1_valid && r1_last)) |=> !r2_valid)
        else $error("snapshot issued without a last sample");

endmodule

/* rtl/snrdb_log.sv */
// Log-ratio pipeline: leading-one log2 of both energies, difference,
// scaling to dB in Q8.8 with rounding and clamp, special-case selection.
// Depends on snrdb_pkg.
module snrdb_log #(
    parameter int LOG_TABLE_BITS = snrdb_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_snap_valid,
    input  snrdb_pkg::t_snap    i_snap,
    output logic                o_res_valid,
    output snrdb_pkg::t_result  o_res
);

    localparam int EW   = snrdb_pkg::ENERGY_WIDTH;
    localparam int PW   = snrdb_pkg::POS_WIDTH;
    localparam int FW   = snrdb_pkg::FRAC_WIDTH;
    localparam int LW   = snrdb_pkg::LOG_WIDTH;
    localparam int XW   = snrdb_pkg::PROD_WIDTH;
    localparam int SW   = snrdb_pkg::SNR_WIDTH;
    localparam int STW  = snrdb_pkg::STATUS_WIDTH;
    localparam int RS   = snrdb_pkg::ROUND_SHIFT;
    localparam int TB   = LOG_TABLE_BITS;
    localparam int TDEP = 2 ** TB;

    logic [FW-1:0] w_tab [TDEP];

    for (genvar g = 0; g < TDEP; g++) begin : g_tab
        localparam logic [FW-1:0] FRAC = snrdb_pkg::log_frac(g, TB);
        assign w_tab[g] = FRAC;
    end

    // stage 3: leading one and table index
    logic            r3_valid;
    logic [PW-1:0]   r3_pos_sig;
    logic [PW-1:0]   r3_pos_err;
    logic [TB-1:0]   r3_idx_sig;
    logic [TB-1:0]   r3_idx_err;
    logic [STW-1:0]  r3_status;
    logic            r3_clip;

    // stage 4: |log2 difference|
    logic            r4_valid;
    logic [LW-1:0]   r4_mag;
    logic            r4_neg;
    logic [STW-1:0]  r4_status;
    logic            r4_clip;

    // stage 5: scaled product
    logic            r5_valid;
    logic [XW-1:0]   r5_prod;
    logic            r5_neg;
    logic [STW-1:0]  r5_status;
    logic            r5_clip;

    logic [PW-1:0]     w_pos_sig;
    logic [PW-1:0]     w_pos_err;
    logic [EW+TB-1:0]  w_norm_sig;
    logic [EW+TB-1:0]  w_norm_err;
    logic              w_zero_sig;
    logic              w_zero_err;
    logic [STW-1:0]    n_status;
    logic [LW-1:0]     w_log_sig;
    logic [LW-1:0]     w_log_err;
    logic signed [LW:0] w_diff;
    logic [LW:0]       w_abs;
    logic [XW:0]       w_round;
    logic [SW-1:0]     w_quot;
    logic signed [SW-1:0] w_mag;
    logic signed [SW-1:0] w_snr;

    assign w_pos_sig  = snrdb_pkg::lead_one(i_snap.sig_energy);
    assign w_pos_err  = snrdb_pkg::lead_one(i_snap.err_energy);
    // bits under the leading one; zeros come in from below bit 0
    assign w_norm_sig = {i_snap.sig_energy, {TB{1'b0}}} >> w_pos_sig;
    assign w_norm_err = {i_snap.err_energy, {TB{1'b0}}} >> w_pos_err;
    assign w_zero_sig = (i_snap.sig_energy == '0);
    assign w_zero_err = (i_snap.err_energy == '0);

    always_comb begin
        if (w_zero_sig && w_zero_err) begin
            n_status = snrdb_pkg::ST_BOTH_ZERO;
        end else if (w_zero_err) begin
            n_status = snrdb_pkg::ST_ERR_ZERO;
        end else if (w_zero_sig) begin
            n_status = snrdb_pkg::ST_SIG_ZERO;
        end else begin
            n_status = snrdb_pkg::ST_NORMAL;
        end
    end

    assign w_log_sig = {r3_pos_sig, w_tab[r3_idx_sig]};
    assign w_log_err = {r3_pos_err, w_tab[r3_idx_err]};
    assign w_diff    = $signed({1'b0, w_log_sig}) - $signed({1'b0, w_log_err});
    assign w_abs     = w_diff[LW] ? $unsigned(-w_diff) : $unsigned(w_diff);

    // round half away from zero on the magnitude, then clamp
    assign w_round = {1'b0, r5_prod} + ((XW + 1)'(1) << (RS - 1));
    assign w_quot  = w_round[XW:RS];
    assign w_mag   = (w_quot > $unsigned(snrdb_pkg::SNR_MAX)) ? snrdb_pkg::SNR_MAX
                                                               : $signed(w_quot);
    assign w_snr   = r5_neg ? -w_mag : w_mag;

    always_comb begin
        o_res.status = r5_status;
        o_res.sat    = r5_clip;
        case (r5_status)
            snrdb_pkg::ST_BOTH_ZERO: o_res.snr = '0;
            snrdb_pkg::ST_ERR_ZERO:  o_res.snr = snrdb_pkg::SNR_MAX;
            snrdb_pkg::ST_SIG_ZERO:  o_res.snr = -snrdb_pkg::SNR_MAX;
            default:                 o_res.snr = w_snr;
        endcase
    end

    assign o_res_valid = r5_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_snap_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pos_sig <= w_pos_sig;
            r3_pos_err <= w_pos_err;
            r3_idx_sig <= w_norm_sig[TB-1:0];
            r3_idx_err <= w_norm_err[TB-1:0];
            r3_status  <= n_status;
            r3_clip    <= i_snap.clip;
            r4_mag     <= w_abs[LW-1:0];
            r4_neg     <= w_diff[LW];
            r4_status  <= r3_status;
            r4_clip    <= r3_clip;
            r5_prod    <= XW'(r4_mag * snrdb_pkg::DB_PER_LOG2_Q16);
            r5_neg     <= r4_neg;
            r5_status  <= r4_status;
            r5_clip    <= r4_clip;
        end
    end

endmodule

/* rtl/snr_db_meter.sv */
// Block SNR meter in dB: energy accumulation, log-ratio pipeline, output skid.
// Depends on snrdb_pkg, snrdb_accum and snrdb_log.
//
// One sample pair is taken in every cycle while o_s_axis_tready is high. Each pair adds original^2 and
// (original - modified)^2 to two 64-bit sums that saturate at full scale;
// the pair marked by tlast closes the block and yields one result,
// 10*log10(signal/error) in signed Q8.8 dB, on the output once it has passed
// the pipeline. The sums clear after that pair, so the next block can start in
// the very next cycle. The depth is set by the squaring stage, the 64-bit
// saturating add, and the four log stages (leading-one search, fraction table
// and subtract, dB multiply, round and clamp). A one-entry skid stage sits
// behind the result register: the input side stalls only once a result is held
// in the skid stage, and o_s_axis_tready is a register output.
module snr_db_meter #(
    parameter int SAMPLE_WIDTH   = snrdb_pkg::SAMPLE_WIDTH_DEF,
    parameter int LOG_TABLE_BITS = snrdb_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // original_sample [SAMPLE_WIDTH-1:0], modified_sample next, zero pad
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,
    input  logic                                  i_s_axis_tvalid,
    input  logic                                  i_s_axis_tlast,
    output logic                                  o_s_axis_tready,
    // snr_db [16:0], zero pad
    output logic [snrdb_pkg::OUT_DATA_WIDTH-1:0]  o_m_axis_tdata,
    // ratio_status [1:0], energy_saturated [2]
    output logic [snrdb_pkg::OUT_USER_WIDTH-1:0]  o_m_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready
);

    localparam int SNW = snrdb_pkg::SNR_WIDTH;
    localparam int ODW = snrdb_pkg::OUT_DATA_WIDTH;

    logic                 w_en;
    logic                 w_snap_valid;
    snrdb_pkg::t_snap     w_snap;
    logic                 w_res_valid;
    snrdb_pkg::t_result   w_res;
    logic                 w_out_take;

    logic                 r_out_valid;
    snrdb_pkg::t_result   r_out;
    logic                 r_skid_valid;
    snrdb_pkg::t_result   r_skid;

    assign w_en            = !r_skid_valid;
    assign o_s_axis_tready = w_en;

    snrdb_accum #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_s_axis_tvalid),
        .i_orig      ($signed(i_s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .i_mod       ($signed(i_s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
        .i_last      (i_s_axis_tlast),
        .o_snap_valid(w_snap_valid),
        .o_snap      (w_snap)
    );

    snrdb_log #(
        .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) u_log (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_snap_valid(w_snap_valid),
        .i_snap      (w_snap),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign w_out_take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out <= r_skid;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(ODW - SNW){1'b0}}, r_out.snr};
    assign o_m_axis_tuser  = {r_out.sat, r_out.status};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result while the output is empty");

    a_both_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == snrdb_pkg::ST_BOTH_ZERO) |-> (r_out.snr == '0))
        else $error("both-zero result not reported as 0 dB");

    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == snrdb_pkg::ST_ERR_ZERO)
            |-> (r_out.snr == snrdb_pkg::SNR_MAX))
        else $error("zero error energy not reported as full scale");

endmodule

/* dv/tb_snr_db_meter.sv */
// Self-checking bench for snr_db_meter: stream stimulus, bit-exact SNR prediction, scoreboard.
// Depends on snrdb_pkg (widths, status codes, result type) and the snr_db_meter RTL.
`timescale 1ns / 1ps

module tb_snr_db_meter;
    import snrdb_pkg::*;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int IN_W        = ((2 * SW + 7) / 8) * 8;
    localparam int LUT_BITS    = LOG_TABLE_BITS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RX_HOLD     = 300;

    // Running energies per block, log2 fraction table and the queue of
    // dB results still owed by the block.
    class block_snr_tally;
        logic [ENERGY_WIDTH-1:0] sig_sum;
        logic [ENERGY_WIDTH-1:0] err_sum;
        bit                      clipped;
        t_result                 owed_snr[$];
        logic [FRAC_WIDTH-1:0]   frac_lut[1 << LUT_BITS];
        int unsigned             n_samples;
        int unsigned             n_results;
        int unsigned             n_errors;
        int unsigned             status_hits[4];

        function new();
            logic [63:0] mant;
            for (int i = 0; i < (1 << LUT_BITS); i++) begin
                mant = (64'd1 << 30) | (64'(i) << (30 - LUT_BITS));
                frac_lut[i] = '0;
                // one fraction bit per squaring; renormalize when it crosses 2.0
                for (int b = FRAC_WIDTH - 1; b >= 0; b--) begin
                    mant = (mant * mant) >> 30;
                    if (mant >= (64'd1 << 31)) begin
                        frac_lut[i][b] = 1'b1;
                        mant = mant >> 1;
                    end
                end
            end
            sig_sum = '0;
            err_sum = '0;
            clipped = 1'b0;
        endfunction

        function logic [ENERGY_WIDTH-1:0] add_clip(logic [ENERGY_WIDTH-1:0] acc,
                                                   logic [ENERGY_WIDTH-1:0] inc);
            logic [ENERGY_WIDTH:0] s;
            s = {1'b0, acc} + {1'b0, inc};
            if (s[ENERGY_WIDTH]) begin
                clipped = 1'b1;
                return '1;
            end
            return s[ENERGY_WIDTH-1:0];
        endfunction

        // unsigned Q6.16 log2 of a nonzero energy
        function longint log2_q16(logic [ENERGY_WIDTH-1:0] v);
            int          p;
            logic [63:0] idx;
            p = ENERGY_WIDTH - 1;
            while (p > 0 && !v[p]) p--;
            if (p >= LUT_BITS) idx = v >> (p - LUT_BITS);
            else idx = v << (LUT_BITS - p);
            return (longint'(p) << FRAC_WIDTH) + longint'(frac_lut[idx[LUT_BITS-1:0]]);
        endfunction

        function void take_sample(logic signed [SW-1:0] orig, logic signed [SW-1:0] modi,
                                  bit last);
            longint  o;
            longint  diff;
            longint  d;
            longint  mag;
            t_result r;
            o    = longint'(orig);
            diff = o - longint'(modi);
            sig_sum = add_clip(sig_sum, 64'(o * o));
            err_sum = add_clip(err_sum, 64'(diff * diff));
            n_samples++;
            if (!last) return;
            if (sig_sum == 0 && err_sum == 0) begin
                r.snr    = '0;
                r.status = ST_BOTH_ZERO;
            end else if (err_sum == 0) begin
                r.snr    = SNR_MAX;
                r.status = ST_ERR_ZERO;
            end else if (sig_sum == 0) begin
                r.snr    = -SNR_MAX;
                r.status = ST_SIG_ZERO;
            end else begin
                d   = log2_q16(sig_sum) - log2_q16(err_sum);
                mag = d < 0 ? -d : d;
                // round half away from zero on the magnitude
                mag = (mag * longint'(DB_PER_LOG2_Q16) + (longint'(1) << (ROUND_SHIFT - 1)))
                      >>> ROUND_SHIFT;
                if (mag > longint'(SNR_MAX)) mag = longint'(SNR_MAX);
                r.snr    = SNR_WIDTH'(d < 0 ? -mag : mag);
                r.status = ST_NORMAL;
            end
            r.sat = clipped;
            owed_snr.push_back(r);
            sig_sum = '0;
            err_sum = '0;
            clipped = 1'b0;
        endfunction

        function void compare_result(logic [OUT_DATA_WIDTH-1:0] data,
                                     logic [OUT_USER_WIDTH-1:0] user);
            t_result                     want;
            logic signed [SNR_WIDTH-1:0] got_snr;
            got_snr = data[SNR_WIDTH-1:0];
            if (owed_snr.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result snr %0d status %0d sat %0d", $time,
                         got_snr, user[STATUS_WIDTH-1:0], user[STATUS_WIDTH]);
                return;
            end
            want = owed_snr.pop_front();
            n_results++;
            status_hits[want.status]++;
            if (got_snr !== want.snr) begin
                n_errors++;
                $display("%0t: snr_db expected %0d actual %0d", $time, want.snr, got_snr);
            end
            if (user[STATUS_WIDTH-1:0] !== want.status) begin
                n_errors++;
                $display("%0t: ratio_status expected %0d actual %0d", $time, want.status,
                         user[STATUS_WIDTH-1:0]);
            end
            if (user[STATUS_WIDTH] !== want.sat) begin
                n_errors++;
                $display("%0t: energy_saturated expected %0d actual %0d", $time, want.sat,
                         user[STATUS_WIDTH]);
            end
        endfunction
    endclass

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    // original_sample [15:0], modified_sample [31:16]
    logic [IN_W-1:0]           i_s_axis_tdata  = '0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      i_s_axis_tlast  = 1'b0;
    logic                      o_s_axis_tready;
    // snr_db [16:0], zero pad
    logic [OUT_DATA_WIDTH-1:0] o_m_axis_tdata;
    // ratio_status [1:0], energy_saturated [2]
    logic [OUT_USER_WIDTH-1:0] o_m_axis_tuser;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;

    block_snr_tally snr_tally = new();

    bit          tx_idle_on  = 1'b0;
    bit          rx_idle_on  = 1'b0;
    bit          rx_hold_req = 1'b0;
    int          rx_gap      = 0;
    int unsigned items_sent  = 0;
    int unsigned blocks_sent = 0;
    int unsigned cycle_count = 0;

    snr_db_meter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                     snr_tally.owed_snr.size());
            $display("** snr_db_meter: FAILED **");
            $finish;
        end
    end

    // handshake monitors: both sides sampled at the edge where the request moves
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            snr_tally.take_sample(i_s_axis_tdata[SW-1:0], i_s_axis_tdata[2*SW-1:SW],
                                  i_s_axis_tlast);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            snr_tally.compare_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // result side: random stall after each taken result while rx_idle_on is set, one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                rx_gap = rx_idle_on ? $urandom_range(0, 7) : 0;
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_gap = RX_HOLD;
            end
            if (rx_gap > 0) begin
                rx_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [SW-1:0] orig, input logic [SW-1:0] modi,
                               input bit last);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata  <= IN_W'({modi, orig});
        i_s_axis_tlast  <= last;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        if (last) blocks_sent++;
    endtask

    // one measured block; the flavor picks how the degraded samples relate
    task automatic send_block(input int unsigned len);
        int unsigned        flavor;
        logic signed [SW-1:0] orig;
        logic signed [SW-1:0] modi;
        logic signed [SW-1:0] delta;
        logic signed [SW-1:0] corner[5];
        corner = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
        flavor = $urandom_range(0, 19);
        for (int unsigned k = 0; k < len; k++) begin
            orig  = SW'($urandom);
            modi  = SW'($urandom);
            delta = SW'($urandom);
            if (flavor >= 19) begin
                orig = corner[$urandom_range(0, 4)];
                modi = corner[$urandom_range(0, 4)];
            end else if (flavor == 18) begin
                orig = '0;
                modi = '0;
            end else if (flavor == 17) begin
                orig = '0;
            end else if (flavor == 16) begin
                modi = orig;
            end else if (flavor >= 13) begin
                orig = orig >>> $urandom_range(0, 15);
                modi = orig + (delta >>> $urandom_range(6, 15));
            end else if (flavor >= 6) begin
                modi = orig + (delta >>> $urandom_range(2, 15));
            end
            send_sample(orig, modi, k == len - 1);
        end
    endtask

    initial begin
        int unsigned phase_end;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero energies, equal samples, full-scale corners, tiny energies
        send_sample(16'h0000, 16'h0000, 1'b1);
        send_sample(16'h7fff, 16'h7fff, 1'b1);
        send_sample(16'h0000, 16'h8000, 1'b1);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h7fff, 1'b1);
        send_sample(16'h7fff, 16'h8000, 1'b1);
        send_sample(16'h0001, 16'h0000, 1'b1);
        send_sample(16'h0001, 16'h0001, 1'b0);
        send_sample(16'h0000, 16'h0000, 1'b1);
        send_sample(16'h8000, 16'h8001, 1'b1);
        send_sample(16'h0001, 16'h8000, 1'b1);
        send_sample(16'h0003, 16'h0002, 1'b0);
        send_sample(16'h0005, 16'h0007, 1'b0);
        send_sample(16'hfffa, 16'hfffa, 1'b1);
        send_sample(16'h0000, 16'h0005, 1'b0);
        send_sample(16'h0000, 16'h0000, 1'b1);
        send_sample(16'h0064, 16'hff9c, 1'b1);
        send_sample(16'hffff, 16'h0000, 1'b1);

        // random blocks in phases with different idling on each side
        for (int ph = 0; ph < 5; ph++) begin
            tx_idle_on = (ph != 1 && ph != 3);
            rx_idle_on = (ph != 1 && ph != 2);
            phase_end  = items_sent + 250;
            while (items_sent < phase_end) begin
                send_block(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 8));
            end
            if (ph == 0) begin
                // back up the result path: one result per request, no sender gaps
                tx_idle_on  = 1'b0;
                rx_hold_req = 1'b1;
                for (int k = 0; k < 40; k++) begin
                    send_sample(SW'($urandom), SW'($urandom), 1'b1);
                end
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (snr_tally.owed_snr.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("covered %0d sample pairs in %0d blocks, %0d results checked",
                 snr_tally.n_samples, blocks_sent, snr_tally.n_results);
        $display("status mix: normal %0d, error zero %0d, signal zero %0d, both zero %0d",
                 snr_tally.status_hits[ST_NORMAL], snr_tally.status_hits[ST_ERR_ZERO],
                 snr_tally.status_hits[ST_SIG_ZERO], snr_tally.status_hits[ST_BOTH_ZERO]);
        if (snr_tally.n_errors == 0) begin
            $display("** snr_db_meter: PASSED **");
        end else begin
            $display("** snr_db_meter: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/snrdb_pkg.sv
rtl/snrdb_accum.sv
rtl/snrdb_log.sv
rtl/snr_db_meter.sv
dv/tb_snr_db_meter.sv
